[design/rroc_pkg.sv]
package rroc_pkg;

  localparam int unsigned SCORE_W = 32;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned TOTAL_W = 64;

  typedef struct packed {
    logic                      is_spam;
    logic signed [SCORE_W-1:0] score;
    logic                      start_new;
  } in_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] inversion_total;
    logic [COUNT_W-1:0] ham_total;
    logic [COUNT_W-1:0] spam_total;
    logic               store_full;
  } out_t;

  // Control bits that ride along with an item from cell to cell.
  typedef struct packed {
    logic vld;
    logic is_spam;
    logic start_new;
    logic placed;
  } ctl_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] a);
    sat_inc = (&a) ? a : a + COUNT_W'(1);
  endfunction

endpackage

[design/running_roc_inversion_counter_top.sv]
// Running ROC inversion counter.
// Input channel (in_valid/in_ready/in_data) takes one labeled score per item;
// the result channel (out_valid/out_ready/out_data) returns one item per input
// item, in order, with the running inversion, ham and spam totals and a flag
// that says the item found no free place in the store.
// The store is a row of MAX_ITEMS cells. An item walks the row one cell per
// cycle while the row is not held, counting misordered partners and settling
// into the first free cell; the item behind it follows one cell later, so it
// always sees the earlier item already in place. A set start_new empties each
// cell as the item passes, but for the cell it settles in. The result passes
// through the cell row and the result register behind it to out_valid. One item
// per cycle is accepted while the result register is free or being taken.
// Reset empties every cell and clears the totals and out_valid; an item may be
// offered in the first cycle after reset.
// When the receiver stalls with a result waiting, the whole row holds still
// and in_ready drops until the result is taken.
module running_roc_inversion_counter_top #(
  parameter int unsigned MAX_ITEMS  = 256,
  parameter int unsigned SCORE_BITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rroc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rroc_pkg::out_t out_data
);
  import rroc_pkg::*;

  localparam int unsigned KEY_BITS = (SCORE_BITS < SCORE_W) ? SCORE_BITS : SCORE_W;
  localparam int unsigned HIT_BITS = $clog2(MAX_ITEMS + 1);

  logic                       en;
  ctl_t                       ctl_w  [0:MAX_ITEMS];
  logic signed [KEY_BITS-1:0] key_w  [0:MAX_ITEMS];
  logic        [HIT_BITS-1:0] hits_w [0:MAX_ITEMS];
  logic        [MAX_ITEMS-1:0] used_vec;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign ctl_w[0]  = '{vld: in_valid, is_spam: in_data.is_spam,
                       start_new: in_data.start_new, placed: 1'b0};
  assign key_w[0]  = in_data.score[KEY_BITS-1:0];
  assign hits_w[0] = '0;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    rroc_cell #(
      .KEY_BITS(KEY_BITS),
      .HIT_BITS(HIT_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .ctl_in  (ctl_w[i]),
      .key_in  (key_w[i]),
      .hits_in (hits_w[i]),
      .ctl_out (ctl_w[i+1]),
      .key_out (key_w[i+1]),
      .hits_out(hits_w[i+1]),
      .used    (used_vec[i])
    );
  end

  rroc_acc #(
    .HIT_BITS(HIT_BITS)
  ) u_acc (
    .rst_n   (rst_n),
    .clk     (clk),
    .en      (en),
    .ctl_in  (ctl_w[MAX_ITEMS]),
    .hits_in (hits_w[MAX_ITEMS]),
    .out_vld (out_valid),
    .out_item(out_data)
  );

`ifndef ASSERT_OFF
  // The head cell is the first to fill after a start and is never emptied
  // without being refilled, so any stored item implies it is occupied.
  a_head_used: assert property (@(posedge clk) disable iff (!rst_n)
    (|used_vec) |-> used_vec[0])
    else $error("store holds items but the head cell is empty");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // Every result counts at least the item that produced it.
  a_counts_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.ham_total != '0 || out_data.spam_total != '0))
    else $error("result with both class totals zero");
`endif

endmodule

[design/rroc_cell.sv]
module rroc_cell #(
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned HIT_BITS = 9
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  rroc_pkg::ctl_t             ctl_in,
  input  logic signed [KEY_BITS-1:0] key_in,
  input  logic        [HIT_BITS-1:0] hits_in,
  output rroc_pkg::ctl_t             ctl_out,
  output logic signed [KEY_BITS-1:0] key_out,
  output logic        [HIT_BITS-1:0] hits_out,
  output logic                       used
);
  import rroc_pkg::*;

  logic                       used_r, used_nxt;
  logic                       cls_r;
  logic signed [KEY_BITS-1:0] key_r;
  ctl_t                       ctl_r, ctl_nxt;
  logic signed [KEY_BITS-1:0] pkey_r;
  logic        [HIT_BITS-1:0] hits_r, hits_nxt;
  logic                       live;
  logic                       hit;
  logic                       place;

  // A start_new item sees the cell as empty and leaves it empty unless it
  // settles here itself.
  always_comb begin
    live = used_r && !ctl_in.start_new;
    if (ctl_in.is_spam) begin
      hit = ctl_in.vld && live && !cls_r && (key_r > key_in);
    end else begin
      hit = ctl_in.vld && live && cls_r && (key_r <= key_in);
    end
    place    = ctl_in.vld && !live && !ctl_in.placed;
    used_nxt = ctl_in.vld ? (live || place) : used_r;
    ctl_nxt  = ctl_in;
    ctl_nxt.placed = ctl_in.placed || place;
    hits_nxt = hits_in + HIT_BITS'(hit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      ctl_r  <= '0;
    end else if (en) begin
      used_r <= used_nxt;
      ctl_r  <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pkey_r <= key_in;
      hits_r <= hits_nxt;
      if (place) begin
        key_r <= key_in;
        cls_r <= ctl_in.is_spam;
      end
    end
  end

  assign ctl_out  = ctl_r;
  assign key_out  = pkey_r;
  assign hits_out = hits_r;
  assign used     = used_r;

endmodule

[design/rroc_acc.sv]
module rroc_acc #(
  parameter int unsigned HIT_BITS = 9
) (
  input  logic                rst_n,
  input  logic                clk,
  input  logic                en,
  input  rroc_pkg::ctl_t      ctl_in,
  input  logic [HIT_BITS-1:0] hits_in,
  output logic                out_vld,
  output rroc_pkg::out_t      out_item
);
  import rroc_pkg::*;

  logic [TOTAL_W-1:0] inv_r, inv_nxt;
  logic [COUNT_W-1:0] ham_r, ham_nxt;
  logic [COUNT_W-1:0] spam_r, spam_nxt;
  logic               out_vld_r;
  out_t               out_item_r;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] inv_base;
  logic [COUNT_W-1:0] ham_base;
  logic [COUNT_W-1:0] spam_base;

  always_comb begin
    inv_base  = ctl_in.start_new ? '0 : inv_r;
    ham_base  = ctl_in.start_new ? '0 : ham_r;
    spam_base = ctl_in.start_new ? '0 : spam_r;
    sum       = {1'b0, inv_base} + {{(TOTAL_W + 1 - HIT_BITS){1'b0}}, hits_in};
    inv_nxt   = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    ham_nxt   = ctl_in.is_spam ? ham_base : sat_inc(ham_base);
    spam_nxt  = ctl_in.is_spam ? sat_inc(spam_base) : spam_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r     <= '0;
      ham_r     <= '0;
      spam_r    <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= ctl_in.vld;
      if (ctl_in.vld) begin
        inv_r  <= inv_nxt;
        ham_r  <= ham_nxt;
        spam_r <= spam_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && ctl_in.vld) begin
      out_item_r.inversion_total <= inv_nxt;
      out_item_r.ham_total       <= ham_nxt;
      out_item_r.spam_total      <= spam_nxt;
      out_item_r.store_full      <= !ctl_in.placed;
    end
  end

  assign out_vld  = out_vld_r;
  assign out_item = out_item_r;

endmodule
